>>> hw/rtl/i2cbb_pkg.sv
// Shared types and constants for the tick-driven I2C bus master.
package i2cbb_pkg;

  localparam int TPU_W       = 14;
  localparam int ACK_TO_W    = 8;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int OPCODE_W    = 3;
  localparam int DELAY_WIDTH_DEF = 16;

  localparam logic [TPU_W-1:0]    TPU_RESET    = 14'd75;
  localparam logic [ACK_TO_W-1:0] ACK_TO_RESET = 8'd250;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'd1;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_WAIT  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ  = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_HOLD = 5'd1,
    PH_ST_LOW  = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WF_A    = 5'd5,
    PH_WF_B    = 5'd6,
    PH_WR_SET  = 5'd7,
    PH_WR_HIGH = 5'd8,
    PH_WR_LOW  = 5'd9,
    PH_WA_REL  = 5'd10,
    PH_WA_HIGH = 5'd11,
    PH_WA_POLL = 5'd12,
    PH_RD_LOW  = 5'd13,
    PH_RD_HIGH = 5'd14,
    PH_RD_AK   = 5'd15,
    PH_RD_AKH  = 5'd16
  } phase_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [7:0]          data_byte;
    logic                send_ack;
    logic                sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } res_t;

endpackage

>>> hw/rtl/i2cbb_seq.sv
// Bus sequencer: phase, counters and line state, advanced by one tick per request.
module i2cbb_seq import i2cbb_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  cmd_t                cmd,
  input  logic [TPU_W-1:0]    ticks_per_us,
  input  logic [ACK_TO_W-1:0] ack_timeout,
  output res_t                res
);

  localparam int PW = TPU_W + 3;
  localparam int CW = (DELAY_WIDTH > PW) ? DELAY_WIDTH : PW;
  localparam logic [CW-1:0] LIM = CW'({DELAY_WIDTH{1'b1}});

  function automatic logic [DELAY_WIDTH-1:0] sat(input logic [PW-1:0] p);
    logic [CW-1:0] w;
    w = CW'(p);
    return (w > LIM) ? DELAY_WIDTH'(LIM) : DELAY_WIDTH'(w);
  endfunction

  logic [DELAY_WIDTH-1:0] dly1, dly2, dly4;

  assign dly1 = sat(PW'(ticks_per_us));
  assign dly2 = sat(PW'(ticks_per_us) << 1);
  assign dly4 = sat(PW'(ticks_per_us) << 2);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [7:0]             shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [7:0]             poll_r, poll_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   dir_r, dir_nxt;
  logic                   ack_flag_r, ack_flag_nxt;
  logic                   ack_choice_r, ack_choice_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   done;
  logic                   rejected;

  assign bit_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    dir_nxt        = dir_r;
    ack_flag_nxt   = ack_flag_r;
    ack_choice_nxt = ack_choice_r;
    held_nxt       = held_r;
    done           = 1'b0;
    rejected       = 1'b0;
    if (phase_r != PH_IDLE) begin
      rejected = (cmd.opcode >= OP_START) && (cmd.opcode <= OP_READ);
      if (phase_r == PH_WA_POLL) begin
        if (!cmd.sda_sample) begin
          scl_nxt      = 1'b0;
          ack_flag_nxt = 1'b1;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else if (poll_r >= ack_timeout) begin
          dir_nxt   = 1'b1;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          delay_nxt = dly4;
          phase_nxt = PH_WF_A;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end else if (delay_r > DELAY_WIDTH'(1)) begin
        delay_nxt = delay_r - DELAY_WIDTH'(1);
      end else begin
        delay_nxt = '0;
        unique case (phase_r)
          PH_ST_HOLD: begin
            sda_nxt = 1'b0; delay_nxt = dly4; phase_nxt = PH_ST_LOW;
          end
          PH_ST_LOW: begin
            scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_SP_A: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; delay_nxt = dly4; phase_nxt = PH_SP_B;
          end
          PH_SP_B: begin
            phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_WF_A: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; delay_nxt = dly4; phase_nxt = PH_WF_B;
          end
          PH_WF_B: begin
            ack_flag_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_WR_SET: begin
            scl_nxt = 1'b1; delay_nxt = dly2; phase_nxt = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_nxt = 1'b0; delay_nxt = dly2; phase_nxt = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              delay_nxt = dly2;
              phase_nxt = PH_WR_SET;
            end
          end
          PH_WA_REL: begin
            scl_nxt = 1'b1; delay_nxt = dly1; phase_nxt = PH_WA_HIGH;
          end
          PH_WA_HIGH: begin
            poll_nxt = '0; phase_nxt = PH_WA_POLL;
          end
          PH_RD_LOW: begin
            scl_nxt = 1'b1; delay_nxt = dly1; phase_nxt = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            shift_nxt   = {shift_r[6:0], cmd.sda_sample};
            bit_cnt_nxt = bit_inc;
            scl_nxt     = 1'b0;
            delay_nxt   = dly2;
            if (bit_inc >= 4'd8) begin
              dir_nxt   = 1'b1;
              sda_nxt   = !ack_choice_r;
              phase_nxt = PH_RD_AK;
            end else begin
              phase_nxt = PH_RD_LOW;
            end
          end
          PH_RD_AK: begin
            scl_nxt = 1'b1; delay_nxt = dly2; phase_nxt = PH_RD_AKH;
          end
          PH_RD_AKH: begin
            scl_nxt   = 1'b0;
            held_nxt  = shift_r;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end else begin
      unique case (cmd.opcode)
        OP_START: begin
          dir_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
          delay_nxt = dly4; phase_nxt = PH_ST_HOLD;
        end
        OP_STOP: begin
          dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
          delay_nxt = dly4; phase_nxt = PH_SP_A;
        end
        OP_WRITE: begin
          dir_nxt     = 1'b1;
          scl_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          sda_nxt     = cmd.data_byte[7];
          shift_nxt   = {cmd.data_byte[6:0], 1'b0};
          delay_nxt   = dly2;
          phase_nxt   = PH_WR_SET;
        end
        OP_WAIT: begin
          dir_nxt = 1'b0; sda_nxt = 1'b1;
          delay_nxt = dly1; phase_nxt = PH_WA_REL;
        end
        OP_READ: begin
          dir_nxt        = 1'b0;
          scl_nxt        = 1'b0;
          bit_cnt_nxt    = '0;
          shift_nxt      = '0;
          ack_choice_nxt = cmd.send_ack;
          delay_nxt      = dly2;
          phase_nxt      = PH_RD_LOW;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      poll_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      dir_r        <= 1'b1;
      ack_flag_r   <= 1'b0;
      ack_choice_r <= 1'b0;
      held_r       <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      delay_r      <= delay_nxt;
      poll_r       <= poll_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      dir_r        <= dir_nxt;
      ack_flag_r   <= ack_flag_nxt;
      ack_choice_r <= ack_choice_nxt;
      held_r       <= held_nxt;
    end
  end

  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.sda_drive    = dir_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.ack_ok       = ack_flag_nxt;
    res.read_data    = held_nxt;
    res.cmd_rejected = rejected;
  end

endmodule

>>> hw/rtl/i2c_bitbang_master.sv
// Top level of the tick-driven I2C bus master: handshakes, configuration and result register.
//
// Each input request is one tick of bus time. It carries a command (or a plain
// tick), the byte to write, the ACK choice for reads and the sampled SDA level.
// Commands are taken only while the sequencer is idle; a command that arrives
// while busy is ignored and flagged in cmd_rejected, and the tick still counts.
// Every request yields exactly one result with the SCL/SDA levels, the SDA
// direction, busy and done flags, the last wait-ack status and the last byte read.
// The sequencer state and the result register are both written at the edge that
// accepts the request. Throughput is one request per cycle while the receiver does
// not stall, set by the single pass through the sequencer's next-state logic.
// When the receiver stalls, the result waits in the output register and in_ready
// stays high only if that result is taken in the same cycle.
// Synchronous reset puts the bus lines high with SDA driven, the sequencer idle,
// ticks_per_us at 75 and ack_timeout at 250. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the block does not enforce it.
module i2c_bitbang_master import i2cbb_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_send_ack,
  input  logic                  in_sda_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_scl_level,
  output logic                  out_sda_level,
  output logic                  out_sda_drive,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic                  out_ack_ok,
  output logic [7:0]            out_read_data,
  output logic                  out_cmd_rejected
);

  logic [TPU_W-1:0]    tpu_r;
  logic [ACK_TO_W-1:0] ack_to_r;
  logic                out_valid_r;
  res_t                res_r;
  res_t                seq_res;
  cmd_t                cmd;
  logic                in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign cmd.opcode     = in_opcode;
  assign cmd.data_byte  = in_data_byte;
  assign cmd.send_ack   = in_send_ack;
  assign cmd.sda_sample = in_sda_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r    <= TPU_RESET;
      ack_to_r <= ACK_TO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_US: tpu_r    <= cfg_data[TPU_W-1:0];
        REG_ACK_TIMEOUT:  ack_to_r <= cfg_data[ACK_TO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  i2cbb_seq #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_fire),
    .cmd          (cmd),
    .ticks_per_us (tpu_r),
    .ack_timeout  (ack_to_r),
    .res          (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (in_fire) begin
        out_valid_r <= 1'b1;
        res_r       <= seq_res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = res_r.scl_level;
  assign out_sda_level    = res_r.sda_level;
  assign out_sda_drive    = res_r.sda_drive;
  assign out_busy_res     = res_r.busy_res;
  assign out_done_res     = res_r.done_res;
  assign out_ack_ok       = res_r.ack_ok;
  assign out_read_data    = res_r.read_data;
  assign out_cmd_rejected = res_r.cmd_rejected;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_res |-> !out_busy_res)
    else $error("command reported done while still busy");

  a_ack_rise_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ack_ok) |-> out_done_res)
    else $error("acknowledge status set without a finished wait-ack");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the tick-driven I2C bus master: bus sequencer predictor and request driver.
import i2cbb_pkg::*;

class i2c_line_scoreboard;
  logic [TPU_W-1:0]    tpu;
  logic [ACK_TO_W-1:0] ack_lim;
  phase_t              ph;
  logic [3:0]          nbits;
  logic [7:0]          shreg;
  longint unsigned     dly;
  logic [7:0]          polls;
  logic                scl;
  logic                sda;
  logic                drv;
  logic                ack_flag;
  logic                ack_sel;
  logic [7:0]          rx_byte;
  res_t                line_q[$];
  int unsigned         failures;
  int unsigned         acks;
  int unsigned         timeouts;
  int unsigned         rejects;

  function new();
    tpu      = TPU_RESET;
    ack_lim  = ACK_TO_RESET;
    ph       = PH_IDLE;
    nbits    = '0;
    shreg    = '0;
    dly      = 0;
    polls    = '0;
    scl      = 1'b1;
    sda      = 1'b1;
    drv      = 1'b1;
    ack_flag = 1'b0;
    ack_sel  = 1'b0;
    rx_byte  = '0;
    failures = 0;
    acks     = 0;
    timeouts = 0;
    rejects  = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_TICKS_PER_US) begin
      tpu = val[TPU_W-1:0];
    end else begin
      ack_lim = val[ACK_TO_W-1:0];
    end
  endfunction

  function bit busy();
    return ph != PH_IDLE;
  endfunction

  function int pending();
    return line_q.size();
  endfunction

  function void load_delay(int unsigned us);
    longint unsigned span;
    longint unsigned lim;
    lim  = (longint'(1) << DELAY_WIDTH_DEF) - 1;
    span = longint'(tpu) * us;
    dly  = (span > lim) ? lim : span;
  endfunction

  function void shift_out_bit();
    sda   = shreg[7];
    shreg = {shreg[6:0], 1'b0};
    load_delay(2);
    ph = PH_WR_SET;
  endfunction

  // Performs the step that follows an expired delay; returns 1 when the command is done.
  function bit step_phase(logic sample);
    case (ph)
      PH_ST_HOLD: begin
        sda = 1'b0; load_delay(4); ph = PH_ST_LOW; return 1'b0;
      end
      PH_ST_LOW: begin
        scl = 1'b0; ph = PH_IDLE; return 1'b1;
      end
      PH_SP_A: begin
        scl = 1'b1; sda = 1'b1; load_delay(4); ph = PH_SP_B; return 1'b0;
      end
      PH_SP_B: begin
        ph = PH_IDLE; return 1'b1;
      end
      PH_WF_A: begin
        scl = 1'b1; sda = 1'b1; load_delay(4); ph = PH_WF_B; return 1'b0;
      end
      PH_WF_B: begin
        ack_flag = 1'b0; ph = PH_IDLE; return 1'b1;
      end
      PH_WR_SET: begin
        scl = 1'b1; load_delay(2); ph = PH_WR_HIGH; return 1'b0;
      end
      PH_WR_HIGH: begin
        scl = 1'b0; load_delay(2); ph = PH_WR_LOW; return 1'b0;
      end
      PH_WR_LOW: begin
        nbits = nbits + 4'd1;
        if (nbits >= 4'd8) begin
          ph = PH_IDLE;
          return 1'b1;
        end
        shift_out_bit();
        return 1'b0;
      end
      PH_WA_REL: begin
        scl = 1'b1; load_delay(1); ph = PH_WA_HIGH; return 1'b0;
      end
      PH_WA_HIGH: begin
        polls = '0; ph = PH_WA_POLL; return 1'b0;
      end
      PH_RD_LOW: begin
        scl = 1'b1; load_delay(1); ph = PH_RD_HIGH; return 1'b0;
      end
      PH_RD_HIGH: begin
        shreg = {shreg[6:0], sample};
        nbits = nbits + 4'd1;
        scl   = 1'b0;
        load_delay(2);
        if (nbits >= 4'd8) begin
          drv = 1'b1;
          sda = ack_sel ? 1'b0 : 1'b1;
          ph  = PH_RD_AK;
        end else begin
          ph = PH_RD_LOW;
        end
        return 1'b0;
      end
      PH_RD_AK: begin
        scl = 1'b1; load_delay(2); ph = PH_RD_AKH; return 1'b0;
      end
      PH_RD_AKH: begin
        scl = 1'b0; rx_byte = shreg; ph = PH_IDLE; return 1'b1;
      end
      default: begin
        ph = PH_IDLE; return 1'b0;
      end
    endcase
  endfunction

  function void note_request(cmd_t c);
    res_t want;
    bit   done;
    bit   rej;
    done = 1'b0;
    rej  = 1'b0;
    if (ph != PH_IDLE) begin
      if (c.opcode >= OP_START && c.opcode <= OP_READ) begin
        rej = 1'b1;
        rejects++;
      end
      if (ph == PH_WA_POLL) begin
        if (!c.sda_sample) begin
          scl = 1'b0; ack_flag = 1'b1; ph = PH_IDLE; done = 1'b1;
          acks++;
        end else if (polls >= ack_lim) begin
          drv = 1'b1; scl = 1'b0; sda = 1'b0;
          load_delay(4);
          ph = PH_WF_A;
          timeouts++;
        end else begin
          polls = polls + 8'd1;
        end
      end else if (dly > 1) begin
        dly--;
      end else begin
        dly  = 0;
        done = step_phase(c.sda_sample);
      end
    end else begin
      case (c.opcode)
        OP_START: begin
          drv = 1'b1; sda = 1'b1; scl = 1'b1;
          load_delay(4); ph = PH_ST_HOLD;
        end
        OP_STOP: begin
          drv = 1'b1; scl = 1'b0; sda = 1'b0;
          load_delay(4); ph = PH_SP_A;
        end
        OP_WRITE: begin
          drv = 1'b1; scl = 1'b0;
          nbits = '0; shreg = c.data_byte;
          shift_out_bit();
        end
        OP_WAIT: begin
          drv = 1'b0; sda = 1'b1;
          load_delay(1); ph = PH_WA_REL;
        end
        OP_READ: begin
          drv = 1'b0; scl = 1'b0;
          nbits = '0; shreg = '0; ack_sel = c.send_ack;
          load_delay(2); ph = PH_RD_LOW;
        end
        default: begin
        end
      endcase
    end
    want.scl_level    = scl;
    want.sda_level    = sda;
    want.sda_drive    = drv;
    want.busy_res     = (ph != PH_IDLE);
    want.done_res     = done;
    want.ack_ok       = ack_flag;
    want.read_data    = rx_byte;
    want.cmd_rejected = rej;
    line_q.push_back(want);
  endfunction

  function void cmp_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      failures++;
      if (failures <= 10) begin
        $display("Mismatch on %s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      end
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (line_q.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("Result arrived with no request outstanding");
      end
      return;
    end
    want = line_q.pop_front();
    cmp_field("scl_level", want.scl_level, got.scl_level);
    cmp_field("sda_level", want.sda_level, got.sda_level);
    cmp_field("sda_drive", want.sda_drive, got.sda_drive);
    cmp_field("busy_res", want.busy_res, got.busy_res);
    cmp_field("done_res", want.done_res, got.done_res);
    cmp_field("ack_ok", want.ack_ok, got.ack_ok);
    cmp_field("read_data", want.read_data, got.read_data);
    cmp_field("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
  endfunction
endclass

module tb;
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [7:0]            in_data_byte;
  logic                  in_send_ack;
  logic                  in_sda_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_scl_level;
  logic                  out_sda_level;
  logic                  out_sda_drive;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic                  out_ack_ok;
  logic [7:0]            out_read_data;
  logic                  out_cmd_rejected;

  i2c_line_scoreboard sb;
  bit                 quiet = 1'b0;
  int unsigned        n_items = 0;
  int unsigned        n_cmds = 0;
  int unsigned        n_cfg = 0;

  i2c_bitbang_master u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .in_send_ack      (in_send_ack),
    .in_sda_sample    (in_sda_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_sda_drive    (out_sda_drive),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_ack_ok       (out_ack_ok),
    .out_read_data    (out_read_data),
    .out_cmd_rejected (out_cmd_rejected)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit coin(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] data,
                           input logic ack, input logic sample);
    int unsigned gap;
    cmd_t        c;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_data_byte  <= data;
    in_send_ack   <= ack;
    in_sda_sample <= sample;
    do @(posedge clk); while (!(in_valid && in_ready));
    c.opcode     = op;
    c.data_byte  = data;
    c.send_ack   = ack;
    c.sda_sample = sample;
    sb.note_request(c);
    n_items++;
    if (op >= OP_START && op <= OP_READ) n_cmds++;
  endtask

  // Issues one command and keeps ticking until the sequencer is idle again.
  task automatic run_cmd(input logic [OPCODE_W-1:0] op, input logic [7:0] data,
                         input logic ack, input int unsigned hi_pct,
                         input int unsigned noise_pct);
    logic [OPCODE_W-1:0] tick_op;
    send_item(op, data, ack, coin(hi_pct));
    while (sb.busy()) begin
      tick_op = coin(noise_pct) ? OPCODE_W'($urandom_range(1, 7)) : OP_TICK;
      send_item(tick_op, 8'($urandom), 1'($urandom), coin(hi_pct));
    end
  endtask

  task automatic settle_bus();
    while (sb.busy()) begin
      send_item(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    n_cfg++;
  endtask

  task automatic reconfigure(input logic [TPU_W-1:0] tpu, input logic [ACK_TO_W-1:0] ato);
    settle_bus();
    set_reg(REG_TICKS_PER_US, tpu);
    set_reg(REG_ACK_TIMEOUT, {6'($urandom), ato});
  endtask

  task automatic bus_transaction();
    int unsigned n;
    int unsigned hi;
    hi = coin(50) ? 30 : 80;
    run_cmd(OP_START, 8'($urandom), 1'($urandom), 50, 5);
    run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50, 5);
    run_cmd(OP_WAIT, 8'($urandom), 1'($urandom), hi, 5);
    n = $urandom_range(1, 3);
    repeat (n) begin
      if (coin(50)) begin
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50, 5);
        run_cmd(OP_WAIT, 8'($urandom), 1'($urandom), hi, 5);
      end else begin
        run_cmd(OP_READ, 8'($urandom), 1'($urandom), 50, 5);
      end
    end
    run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 50, 5);
  endtask

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned stall;
    res_t        got;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.scl_level    = out_scl_level;
      got.sda_level    = out_sda_level;
      got.sda_drive    = out_sda_drive;
      got.busy_res     = out_busy_res;
      got.done_res     = out_done_res;
      got.ack_ok       = out_ack_ok;
      got.read_data    = out_read_data;
      got.cmd_rejected = out_cmd_rejected;
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned phase_end;
    int unsigned tpu_sel;
    int unsigned ato_sel;
    sb = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_TICK;
    in_data_byte  <= '0;
    in_send_ack   <= 1'b0;
    in_sda_sample <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: an acknowledge wait at the reset rate, answered on the first poll.
    run_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);

    // Zero rate and zero poll tolerance, with commands arriving while busy.
    reconfigure(14'd0, 8'd0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 50, 30);
    run_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
    run_cmd(OP_WAIT, 8'hFF, 1'b1, 100, 0);
    run_cmd(OP_READ, 8'h00, 1'b1, 50, 30);
    run_cmd(OP_READ, 8'hFF, 1'b0, 50, 0);
    send_item(3'd6, 8'hFF, 1'b1, 1'b1);
    send_item(3'd7, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_STOP, 8'h5A, 1'b1, 50, 30);

    reconfigure(14'd1, 8'd255);
    run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
    run_cmd(OP_WRITE, 8'h00, 1'b0, 50, 0);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, 50, 0);
    run_cmd(OP_WAIT, 8'h00, 1'b0, 100, 0);
    run_cmd(OP_WAIT, 8'h00, 1'b0, 70, 0);
    run_cmd(OP_READ, 8'h00, 1'b1, 100, 0);
    run_cmd(OP_READ, 8'h00, 1'b0, 0, 0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 50, 0);

    for (int p = 0; p < 3; p++) begin
      tpu_sel = (p == 0) ? 0 : (p == 1) ? 1 : $urandom_range(2, 3);
      ato_sel = (p == 2) ? 255 : $urandom_range(0, 6);
      reconfigure(TPU_W'(tpu_sel), ACK_TO_W'(ato_sel));
      quiet = (p == 1);
      phase_end = n_items + 20;
      while (n_items < phase_end) begin
        if (coin(70)) begin
          bus_transaction();
        end else if (coin(50)) begin
          run_cmd(OPCODE_W'($urandom_range(1, 5)), 8'($urandom), 1'($urandom),
                  $urandom_range(0, 100), 10);
        end else begin
          send_item(OPCODE_W'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    1'($urandom));
        end
      end
      quiet = 1'b0;
    end

    settle_bus();
    repeat (8) @(posedge clk);
    $display("Run covered %0d requests, %0d bus commands and %0d register writes.",
             n_items, n_cmds, n_cfg);
    $display("Acknowledge waits: %0d acknowledged, %0d timed out; %0d commands rejected.",
             sb.acks, sb.timeouts, sb.rejects);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
